[rtl/ecsm_pkg.sv]
// shared types, constants and codes for the elliptic curve point multiplier
package ecsm_pkg;

  // field and scalar sizes
  localparam int MOD_BITS    = 31;
  localparam int SCALAR_BITS = 32;
  localparam int VAL_W       = 31;
  localparam int SCALAR_W    = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CNT_W       = $clog2(SCALAR_BITS + 1);
  localparam int MUL_CNT_W   = (VAL_W > 1) ? $clog2(VAL_W) : 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_P = CFG_IDX_W'(1);

  typedef struct packed {
    logic [SCALAR_W-1:0] scalar;
    logic [VAL_W-1:0]    point_x;
    logic [VAL_W-1:0]    point_y;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_x;
    logic [VAL_W-1:0] result_y;
    logic             at_infinity;
  } out_t;

  // datapath operand and destination selects
  typedef enum logic [3:0] {
    REG_ZERO, REG_ONE, REG_AX, REG_AY, REG_BX, REG_BY,
    REG_A, REG_T, REG_U, REG_LAM, REG_IA, REG_IB
  } reg_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_MUL,
    OP_EINIT, OP_ESHIFT, OP_KSHIFT, OP_SETINF, OP_COPYB
  } op_t;

  typedef struct packed {
    op_t  op;
    reg_t src_a;
    reg_t src_b;
    reg_t dst;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic a_inf;
    logic ay_zero;
    logic b_inf;
    logic x_eq;
    logic y_eq;
    logic e_zero;
    logic e_lsb;
    logic k_msb;
    logic p_small;
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RBX, S_RBY, S_RA, S_LOOP,
    S_DBL, S_D1, S_D2, S_D3, S_D4, S_D5,
    S_INV0, S_INV1, S_INV2, S_INVL, S_INVM, S_INVS, S_INVE, S_LAM,
    S_D6, S_D7, S_D8, S_D9, S_D10, S_D11, S_D12,
    S_AFTER, S_ADD, S_A1, S_A2,
    S_A5, S_A6, S_A7, S_A8, S_A9, S_A10, S_A11,
    S_NEXT, S_FINISH
  } state_t;

endpackage

[rtl/ecsm_mulmod.sv]
// bit-serial interleaved modular multiplier, a doubling step and a conditional add step per multiplier bit
module ecsm_mulmod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ecsm_pkg::VAL_W-1:0]  u,
  input  logic [ecsm_pkg::VAL_W-1:0]  v,
  input  logic [ecsm_pkg::VAL_W-1:0]  p,
  output logic                        busy,
  output logic                        done,
  output logic [ecsm_pkg::VAL_W-1:0]  res
);

  logic                              busy_r, busy_nxt;
  logic                              phase_r, phase_nxt;
  logic [ecsm_pkg::MUL_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ecsm_pkg::VAL_W-1:0]        r_r, r_nxt;
  logic [ecsm_pkg::VAL_W-1:0]        u_r, u_nxt;
  logic [ecsm_pkg::VAL_W-1:0]        v_r, v_nxt;
  logic [ecsm_pkg::VAL_W:0]          dbl;
  logic [ecsm_pkg::VAL_W:0]          sum;
  logic [ecsm_pkg::VAL_W-1:0]        dbl_red;
  logic [ecsm_pkg::VAL_W-1:0]        add_red;

  // doubling step and conditional add step, each reduced once
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= {1'b0, p}) ? ecsm_pkg::VAL_W'(dbl - {1'b0, p})
                                 : ecsm_pkg::VAL_W'(dbl);
    sum     = {1'b0, r_r} + {1'b0, u_r};
    if (v_r[ecsm_pkg::VAL_W-1]) begin
      add_red = (sum >= {1'b0, p}) ? ecsm_pkg::VAL_W'(sum - {1'b0, p})
                                   : ecsm_pkg::VAL_W'(sum);
    end else begin
      add_red = r_r;
    end
  end

  // sequencing
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt  = 1'b1;
        phase_nxt = 1'b0;
        cnt_nxt   = ecsm_pkg::MUL_CNT_W'(ecsm_pkg::VAL_W - 1);
        r_nxt     = '0;
        u_nxt     = u;
        v_nxt     = v;
      end
    end else if (!phase_r) begin
      r_nxt     = dbl_red;
      phase_nxt = 1'b1;
    end else begin
      r_nxt     = add_red;
      v_nxt     = {v_r[ecsm_pkg::VAL_W-2:0], 1'b0};
      phase_nxt = 1'b0;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
    r_r <= r_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
  end

  assign busy = busy_r;
  assign done = busy_r && phase_r && (cnt_r == '0);
  assign res  = add_red;

  // a started multiply makes the unit busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r)
    else $error("multiplier did not start");

  // the last step leaves the unit idle
  assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r)
    else $error("multiplier stayed busy after done");

endmodule

[rtl/ecsm_datapath.sv]
// operand registers, modular add and subtract, multiplier and status flags
module ecsm_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ecsm_pkg::cmd_t                    cmd,
  input  ecsm_pkg::in_t                     in_data,
  input  logic [ecsm_pkg::VAL_W-1:0]        cfg_a,
  input  logic [ecsm_pkg::VAL_W-1:0]        cfg_p,
  output ecsm_pkg::stat_t                   stat,
  output ecsm_pkg::out_t                    result
);

  localparam logic [ecsm_pkg::VAL_W-1:0] PMASK =
    ecsm_pkg::VAL_W'((64'd1 << ecsm_pkg::MOD_BITS) - 64'd1);

  logic [ecsm_pkg::VAL_W-1:0] ax_r, ay_r, bx_r, by_r, a_r, t_r, u_r;
  logic [ecsm_pkg::VAL_W-1:0] lam_r, ia_r, ib_r, e_r;
  logic [ecsm_pkg::SCALAR_BITS-1:0] k_r;
  logic                       ainf_r;
  logic [ecsm_pkg::VAL_W-1:0] p;
  logic [ecsm_pkg::VAL_W-1:0] va, vb;
  logic [ecsm_pkg::VAL_W:0]   sum;
  logic [ecsm_pkg::VAL_W-1:0] add_res, sub_res, wr_val;
  logic                       wr_en;
  logic                       mul_start, mul_busy, mul_done;
  logic [ecsm_pkg::VAL_W-1:0] mul_res;

  assign p = cfg_p & PMASK;

  function automatic logic [ecsm_pkg::VAL_W-1:0] pick(
    input ecsm_pkg::reg_t sel,
    input logic [ecsm_pkg::VAL_W-1:0] ax, ay, bx, by, a, t, u, lam, ia, ib
  );
    logic [ecsm_pkg::VAL_W-1:0] val;
    unique case (sel)
      ecsm_pkg::REG_ZERO: val = '0;
      ecsm_pkg::REG_ONE:  val = ecsm_pkg::VAL_W'(1);
      ecsm_pkg::REG_AX:   val = ax;
      ecsm_pkg::REG_AY:   val = ay;
      ecsm_pkg::REG_BX:   val = bx;
      ecsm_pkg::REG_BY:   val = by;
      ecsm_pkg::REG_A:    val = a;
      ecsm_pkg::REG_T:    val = t;
      ecsm_pkg::REG_U:    val = u;
      ecsm_pkg::REG_LAM:  val = lam;
      ecsm_pkg::REG_IA:   val = ia;
      ecsm_pkg::REG_IB:   val = ib;
      default:            val = '0;
    endcase
    return val;
  endfunction

  // operand selection
  assign va = pick(cmd.src_a, ax_r, ay_r, bx_r, by_r, a_r, t_r, u_r, lam_r, ia_r, ib_r);
  assign vb = pick(cmd.src_b, ax_r, ay_r, bx_r, by_r, a_r, t_r, u_r, lam_r, ia_r, ib_r);

  // modular add and subtract of reduced operands
  always_comb begin
    sum     = {1'b0, va} + {1'b0, vb};
    add_res = (sum >= {1'b0, p}) ? ecsm_pkg::VAL_W'(sum - {1'b0, p})
                                 : ecsm_pkg::VAL_W'(sum);
    sub_res = (va < vb) ? (va - vb + p) : (va - vb);
  end

  // multiplier, u must be reduced, v may be any word
  assign mul_start = (cmd.op == ecsm_pkg::OP_MUL) && !mul_busy;

  ecsm_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .u     (va),
    .v     (vb),
    .p     (p),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res)
  );

  // write-back select
  always_comb begin
    wr_en  = 1'b0;
    wr_val = add_res;
    case (cmd.op)
      ecsm_pkg::OP_ADD: begin
        wr_en  = 1'b1;
        wr_val = add_res;
      end
      ecsm_pkg::OP_SUB: begin
        wr_en  = 1'b1;
        wr_val = sub_res;
      end
      ecsm_pkg::OP_MUL: begin
        wr_en  = mul_done;
        wr_val = mul_res;
      end
      default: begin
        wr_en  = 1'b0;
        wr_val = add_res;
      end
    endcase
  end

  // accumulator point and infinity flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r   <= '0;
      ay_r   <= '0;
      ainf_r <= 1'b1;
    end else if (cmd.op == ecsm_pkg::OP_LOAD || cmd.op == ecsm_pkg::OP_SETINF) begin
      ax_r   <= '0;
      ay_r   <= '0;
      ainf_r <= 1'b1;
    end else if (cmd.op == ecsm_pkg::OP_COPYB) begin
      ax_r   <= bx_r;
      ay_r   <= by_r;
      ainf_r <= (bx_r == '0) && (by_r == '0);
    end else if (wr_en && cmd.dst == ecsm_pkg::REG_AX) begin
      ax_r <= wr_val;
    end else if (wr_en && cmd.dst == ecsm_pkg::REG_AY) begin
      ay_r <= wr_val;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.op == ecsm_pkg::OP_LOAD) begin
      bx_r <= in_data.point_x;
      by_r <= in_data.point_y;
      a_r  <= cfg_a & PMASK;
      k_r  <= ecsm_pkg::SCALAR_BITS'(in_data.scalar);
    end else begin
      if (cmd.op == ecsm_pkg::OP_KSHIFT) begin
        k_r <= k_r << 1;
      end
      if (wr_en) begin
        case (cmd.dst)
          ecsm_pkg::REG_BX:  bx_r  <= wr_val;
          ecsm_pkg::REG_BY:  by_r  <= wr_val;
          ecsm_pkg::REG_A:   a_r   <= wr_val;
          ecsm_pkg::REG_T:   t_r   <= wr_val;
          ecsm_pkg::REG_U:   u_r   <= wr_val;
          ecsm_pkg::REG_LAM: lam_r <= wr_val;
          ecsm_pkg::REG_IA:  ia_r  <= wr_val;
          ecsm_pkg::REG_IB:  ib_r  <= wr_val;
          default: ;
        endcase
      end
    end
    if (cmd.op == ecsm_pkg::OP_EINIT) begin
      e_r <= p - ecsm_pkg::VAL_W'(2);
    end else if (cmd.op == ecsm_pkg::OP_ESHIFT) begin
      e_r <= e_r >> 1;
    end
  end

  // status to the controller
  always_comb begin
    stat.mul_done = mul_done;
    stat.a_inf    = ainf_r;
    stat.ay_zero  = (ay_r == '0);
    stat.b_inf    = (bx_r == '0) && (by_r == '0);
    stat.x_eq     = (ax_r == bx_r);
    stat.y_eq     = (ay_r == by_r);
    stat.e_zero   = (e_r == '0);
    stat.e_lsb    = e_r[0];
    stat.k_msb    = k_r[ecsm_pkg::SCALAR_BITS-1];
    stat.p_small  = (p < ecsm_pkg::VAL_W'(3));
  end

  assign result.result_x    = ax_r;
  assign result.result_y    = ay_r;
  assign result.at_infinity = ainf_r;

  // infinity always carries zero coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    ainf_r |-> (ax_r == '0 && ay_r == '0))
    else $error("infinity with nonzero coordinates");

  // a multiply result never lands while no multiply is commanded
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (cmd.op == ecsm_pkg::OP_MUL))
    else $error("multiply finished without a multiply command");

endmodule

[rtl/ecsm_ctrl.sv]
// controller: double-and-add sequence, point formulas and Fermat inversion
module ecsm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ecsm_pkg::stat_t  stat,
  output ecsm_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid
);

  ecsm_pkg::state_t                state_r, state_nxt;
  logic [ecsm_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            in_add_r, in_add_nxt;
  logic                            mode_dbl_r, mode_dbl_nxt;

  function automatic ecsm_pkg::cmd_t mk(
    input ecsm_pkg::op_t op,
    input ecsm_pkg::reg_t a,
    input ecsm_pkg::reg_t b,
    input ecsm_pkg::reg_t d
  );
    ecsm_pkg::cmd_t c;
    c.op    = op;
    c.src_a = a;
    c.src_b = b;
    c.dst   = d;
    return c;
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ecsm_pkg::S_IDLE;
      cnt_r      <= '0;
      in_add_r   <= 1'b0;
      mode_dbl_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      in_add_r   <= in_add_nxt;
      mode_dbl_r <= mode_dbl_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_add_nxt   = in_add_r;
    mode_dbl_nxt = mode_dbl_r;
    cmd = mk(ecsm_pkg::OP_NOP, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO);
    unique case (state_r)
      ecsm_pkg::S_IDLE: begin
        if (start) begin
          cmd        = mk(ecsm_pkg::OP_LOAD, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                          ecsm_pkg::REG_ZERO);
          cnt_nxt    = ecsm_pkg::CNT_W'(ecsm_pkg::SCALAR_BITS);
          in_add_nxt = 1'b0;
          state_nxt  = stat.p_small ? ecsm_pkg::S_FINISH : ecsm_pkg::S_RBX;
        end
      end
      // reduce the raw inputs by multiplying with one
      ecsm_pkg::S_RBX: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_ONE, ecsm_pkg::REG_BX, ecsm_pkg::REG_BX);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_RBY;
      end
      ecsm_pkg::S_RBY: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_ONE, ecsm_pkg::REG_BY, ecsm_pkg::REG_BY);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_RA;
      end
      ecsm_pkg::S_RA: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_ONE, ecsm_pkg::REG_A, ecsm_pkg::REG_A);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_LOOP;
      end
      // scalar bit loop, msb first
      ecsm_pkg::S_LOOP: begin
        state_nxt = (cnt_r == '0) ? ecsm_pkg::S_FINISH : ecsm_pkg::S_DBL;
      end
      ecsm_pkg::S_DBL: begin
        if (stat.a_inf || stat.ay_zero) begin
          cmd = mk(ecsm_pkg::OP_SETINF, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                   ecsm_pkg::REG_ZERO);
          state_nxt = ecsm_pkg::S_AFTER;
        end else begin
          mode_dbl_nxt = 1'b1;
          state_nxt    = ecsm_pkg::S_D1;
        end
      end
      // numerator 3x^2 + a into u, denominator 2y into t
      ecsm_pkg::S_D1: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_AX, ecsm_pkg::REG_AX, ecsm_pkg::REG_T);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_D2;
      end
      ecsm_pkg::S_D2: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_T, ecsm_pkg::REG_T, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_D3;
      end
      ecsm_pkg::S_D3: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_U, ecsm_pkg::REG_T, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_D4;
      end
      ecsm_pkg::S_D4: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_U, ecsm_pkg::REG_A, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_D5;
      end
      ecsm_pkg::S_D5: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_AY, ecsm_pkg::REG_AY, ecsm_pkg::REG_T);
        state_nxt = ecsm_pkg::S_INV0;
      end
      // inverse of t by square-and-multiply over p-2
      ecsm_pkg::S_INV0: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_T, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_IB);
        state_nxt = ecsm_pkg::S_INV1;
      end
      ecsm_pkg::S_INV1: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_ONE, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_IA);
        state_nxt = ecsm_pkg::S_INV2;
      end
      ecsm_pkg::S_INV2: begin
        cmd = mk(ecsm_pkg::OP_EINIT, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                 ecsm_pkg::REG_ZERO);
        state_nxt = ecsm_pkg::S_INVL;
      end
      ecsm_pkg::S_INVL: begin
        if (stat.e_zero) state_nxt = ecsm_pkg::S_LAM;
        else if (stat.e_lsb) state_nxt = ecsm_pkg::S_INVM;
        else state_nxt = ecsm_pkg::S_INVS;
      end
      ecsm_pkg::S_INVM: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_IA, ecsm_pkg::REG_IB, ecsm_pkg::REG_IA);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_INVS;
      end
      ecsm_pkg::S_INVS: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_IB, ecsm_pkg::REG_IB, ecsm_pkg::REG_IB);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_INVE;
      end
      ecsm_pkg::S_INVE: begin
        cmd = mk(ecsm_pkg::OP_ESHIFT, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                 ecsm_pkg::REG_ZERO);
        state_nxt = ecsm_pkg::S_INVL;
      end
      // slope
      ecsm_pkg::S_LAM: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_U, ecsm_pkg::REG_IA, ecsm_pkg::REG_LAM);
        if (stat.mul_done) state_nxt = mode_dbl_r ? ecsm_pkg::S_D6 : ecsm_pkg::S_A5;
      end
      // doubling tail
      ecsm_pkg::S_D6: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_LAM, ecsm_pkg::REG_LAM, ecsm_pkg::REG_T);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_D7;
      end
      ecsm_pkg::S_D7: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_AX, ecsm_pkg::REG_AX, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_D8;
      end
      ecsm_pkg::S_D8: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_T, ecsm_pkg::REG_U, ecsm_pkg::REG_T);
        state_nxt = ecsm_pkg::S_D9;
      end
      ecsm_pkg::S_D9: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_AX, ecsm_pkg::REG_T, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_D10;
      end
      ecsm_pkg::S_D10: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_LAM, ecsm_pkg::REG_U, ecsm_pkg::REG_U);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_D11;
      end
      ecsm_pkg::S_D11: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_U, ecsm_pkg::REG_AY, ecsm_pkg::REG_AY);
        state_nxt = ecsm_pkg::S_D12;
      end
      ecsm_pkg::S_D12: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_T, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_AX);
        state_nxt = ecsm_pkg::S_AFTER;
      end
      ecsm_pkg::S_AFTER: begin
        if (!in_add_r && stat.k_msb) begin
          in_add_nxt = 1'b1;
          state_nxt  = ecsm_pkg::S_ADD;
        end else begin
          state_nxt = ecsm_pkg::S_NEXT;
        end
      end
      // point addition and its special cases
      ecsm_pkg::S_ADD: begin
        if (stat.a_inf) begin
          cmd = mk(ecsm_pkg::OP_COPYB, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                   ecsm_pkg::REG_ZERO);
          state_nxt = ecsm_pkg::S_NEXT;
        end else if (stat.b_inf) begin
          state_nxt = ecsm_pkg::S_NEXT;
        end else if (stat.x_eq) begin
          if (stat.y_eq) begin
            state_nxt = ecsm_pkg::S_DBL;
          end else begin
            cmd = mk(ecsm_pkg::OP_SETINF, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                     ecsm_pkg::REG_ZERO);
            state_nxt = ecsm_pkg::S_NEXT;
          end
        end else begin
          state_nxt = ecsm_pkg::S_A1;
        end
      end
      ecsm_pkg::S_A1: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_BY, ecsm_pkg::REG_AY, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_A2;
      end
      ecsm_pkg::S_A2: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_BX, ecsm_pkg::REG_AX, ecsm_pkg::REG_T);
        mode_dbl_nxt = 1'b0;
        state_nxt    = ecsm_pkg::S_INV0;
      end
      ecsm_pkg::S_A5: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_LAM, ecsm_pkg::REG_LAM, ecsm_pkg::REG_T);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_A6;
      end
      ecsm_pkg::S_A6: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_T, ecsm_pkg::REG_AX, ecsm_pkg::REG_T);
        state_nxt = ecsm_pkg::S_A7;
      end
      ecsm_pkg::S_A7: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_T, ecsm_pkg::REG_BX, ecsm_pkg::REG_T);
        state_nxt = ecsm_pkg::S_A8;
      end
      ecsm_pkg::S_A8: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_AX, ecsm_pkg::REG_T, ecsm_pkg::REG_U);
        state_nxt = ecsm_pkg::S_A9;
      end
      ecsm_pkg::S_A9: begin
        cmd = mk(ecsm_pkg::OP_MUL, ecsm_pkg::REG_LAM, ecsm_pkg::REG_U, ecsm_pkg::REG_U);
        if (stat.mul_done) state_nxt = ecsm_pkg::S_A10;
      end
      ecsm_pkg::S_A10: begin
        cmd = mk(ecsm_pkg::OP_SUB, ecsm_pkg::REG_U, ecsm_pkg::REG_AY, ecsm_pkg::REG_AY);
        state_nxt = ecsm_pkg::S_A11;
      end
      ecsm_pkg::S_A11: begin
        cmd = mk(ecsm_pkg::OP_ADD, ecsm_pkg::REG_T, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_AX);
        state_nxt = ecsm_pkg::S_NEXT;
      end
      ecsm_pkg::S_NEXT: begin
        cmd = mk(ecsm_pkg::OP_KSHIFT, ecsm_pkg::REG_ZERO, ecsm_pkg::REG_ZERO,
                 ecsm_pkg::REG_ZERO);
        cnt_nxt    = cnt_r - 1'b1;
        in_add_nxt = 1'b0;
        state_nxt  = ecsm_pkg::S_LOOP;
      end
      ecsm_pkg::S_FINISH: begin
        state_nxt = ecsm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ecsm_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ecsm_pkg::S_IDLE);
  assign out_valid = (state_r == ecsm_pkg::S_FINISH);

  // one strobe per item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a degenerate modulus answers at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecsm_pkg::S_IDLE && start && stat.p_small) |=> out_valid)
    else $error("small modulus did not finish at once");

  // slope feeds one of the two tails
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecsm_pkg::S_LAM && stat.mul_done) |=>
      (state_r == ecsm_pkg::S_D6 || state_r == ecsm_pkg::S_A5))
    else $error("slope not followed by a point tail");

endmodule

[rtl/ecc_scalar_point_multiply.sv]
// Scalar point multiplier on y^2 = x^3 + ax + b mod p in affine coordinates.
// Pulse start while busy is low with a scalar k and a point; (0,0) is the
// point at infinity. After the run out_valid is high for one cycle with
// k*P, or at_infinity set and zero coordinates; the receiver cannot stall,
// so take the word in that cycle. The scalar is scanned msb first,
// doubling and adding, and every doubling or addition that is not a
// special case takes one Fermat inversion. All field work goes through
// one bit-serial modular multiplier, so run time is set by that unit:
// up to 132 products per scalar bit (the exponent p-2 has up to 31 bits,
// so up to 62 products per inversion, plus four for a doubling and three
// for an addition, which falls back to a second doubling when the two
// points are equal). Three products reduce the inputs first, and a
// modulus below 3 answers in the cycle right after start is taken.
// Write curve_a and modulus_p only while busy is low.
module ecc_scalar_point_multiply (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  ecsm_pkg::in_t                        in_data,
  output logic                                 out_valid,
  output ecsm_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [ecsm_pkg::VAL_W-1:0] curve_a_r;
  logic [ecsm_pkg::VAL_W-1:0] modulus_p_r;
  ecsm_pkg::cmd_t             cmd;
  ecsm_pkg::stat_t            stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r   <= '0;
      modulus_p_r <= ecsm_pkg::VAL_W'(3);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ecsm_pkg::CFG_CURVE_A:   curve_a_r   <= cfg_data[ecsm_pkg::VAL_W-1:0];
        ecsm_pkg::CFG_MODULUS_P: modulus_p_r <= cfg_data[ecsm_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ecsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // field arithmetic and point registers
  ecsm_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .cfg_a   (curve_a_r),
    .cfg_p   (modulus_p_r),
    .stat    (stat),
    .result  (out_data)
  );

endmodule

[test/tb.sv]
// self-checking testbench for the elliptic curve scalar point multiplier
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 3000000;
  localparam longint unsigned VAL_MASK = 64'h7FFF_FFFF;

  typedef struct {
    longint unsigned x;
    longint unsigned y;
    bit              inf;
  } curve_pt_t;

  // expected point products and the field settings they are computed under
  class point_product_sb;
    ecsm_pkg::out_t  pending_q[$];
    longint unsigned coef_a;
    longint unsigned prime_p;
    int              errors;

    function new();
      coef_a  = 0;
      prime_p = 3;
      errors  = 0;
    endfunction

    function void set_reg(logic [ecsm_pkg::CFG_IDX_W-1:0] idx,
                          logic [ecsm_pkg::CFG_DATA_W-1:0] val);
      if (idx == ecsm_pkg::CFG_CURVE_A) coef_a = val & VAL_MASK;
      else if (idx == ecsm_pkg::CFG_MODULUS_P) prime_p = val & VAL_MASK;
    endfunction

    function longint unsigned fmul(longint unsigned u, longint unsigned v);
      return (u * v) % prime_p;
    endfunction

    function longint unsigned fsub(longint unsigned u, longint unsigned v);
      return (u + prime_p - v) % prime_p;
    endfunction

    // fermat inversion, v^(p-2)
    function longint unsigned finv(longint unsigned v);
      longint unsigned e, acc, b;
      e   = prime_p - 2;
      acc = 1 % prime_p;
      b   = v % prime_p;
      while (e != 0) begin
        if (e[0]) acc = fmul(acc, b);
        b = fmul(b, b);
        e = e >> 1;
      end
      return acc;
    endfunction

    function curve_pt_t pt_dbl(curve_pt_t s, longint unsigned a);
      curve_pt_t r;
      longint unsigned num, lam;
      r.x = 0; r.y = 0; r.inf = 1;
      if (s.inf || s.y == 0) return r;
      num = (fmul(3, fmul(s.x, s.x)) + a) % prime_p;
      lam = fmul(num, finv((2 * s.y) % prime_p));
      r.x = fsub(fmul(lam, lam), (2 * s.x) % prime_p);
      r.y = fsub(fmul(lam, fsub(s.x, r.x)), s.y);
      r.inf = 0;
      return r;
    endfunction

    function curve_pt_t pt_add(curve_pt_t s, curve_pt_t t, longint unsigned a);
      curve_pt_t r;
      longint unsigned lam;
      if (s.inf) return t;
      if (t.inf) return s;
      r.x = 0; r.y = 0; r.inf = 1;
      if (s.x == t.x) begin
        if (s.y == t.y) return pt_dbl(s, a);
        return r;
      end
      lam = fmul(fsub(t.y, s.y), finv(fsub(t.x, s.x)));
      r.x = fsub(fsub(fmul(lam, lam), s.x), t.x);
      r.y = fsub(fmul(lam, fsub(s.x, r.x)), s.y);
      r.inf = 0;
      return r;
    endfunction

    // double-and-add from the top scalar bit
    function void note_word(ecsm_pkg::in_t w);
      ecsm_pkg::out_t  res;
      curve_pt_t       base, acc;
      longint unsigned a;
      res.result_x    = '0;
      res.result_y    = '0;
      res.at_infinity = 1'b1;
      if (prime_p >= 3) begin
        a        = coef_a % prime_p;
        base.x   = longint'(w.point_x) % prime_p;
        base.y   = longint'(w.point_y) % prime_p;
        base.inf = (base.x == 0 && base.y == 0);
        acc.x = 0; acc.y = 0; acc.inf = 1;
        for (int i = ecsm_pkg::SCALAR_BITS - 1; i >= 0; i--) begin
          acc = pt_dbl(acc, a);
          if (w.scalar[i]) acc = pt_add(acc, base, a);
        end
        if (!acc.inf) begin
          res.result_x    = acc.x[ecsm_pkg::VAL_W-1:0];
          res.result_y    = acc.y[ecsm_pkg::VAL_W-1:0];
          res.at_infinity = 1'b0;
        end
      end
      pending_q.push_back(res);
    endfunction

    function void check_word(ecsm_pkg::out_t got);
      ecsm_pkg::out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.result_x !== want.result_x) begin
        $display("%0t: result_x expected %h got %h", $time, want.result_x, got.result_x);
        errors++;
      end
      if (got.result_y !== want.result_y) begin
        $display("%0t: result_y expected %h got %h", $time, want.result_y, got.result_y);
        errors++;
      end
      if (got.at_infinity !== want.at_infinity) begin
        $display("%0t: at_infinity expected %b got %b", $time, want.at_infinity,
                 got.at_infinity);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  ecsm_pkg::in_t                   in_data;
  logic                            out_valid;
  ecsm_pkg::out_t                  out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ecsm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ecsm_pkg::CFG_DATA_W-1:0] cfg_data;

  point_product_sb sb;
  int              idle_cycles;
  int              burst_left;
  logic            small_p;

  ecc_scalar_point_multiply uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_data);
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // present one register write and hold it until taken; caller drops valid
  task automatic write_reg(logic [ecsm_pkg::CFG_IDX_W-1:0] idx,
                           logic [ecsm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // drain all results, then reprogram the field
  task automatic set_field(logic [ecsm_pkg::CFG_DATA_W-1:0] a,
                           logic [ecsm_pkg::CFG_DATA_W-1:0] p);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(ecsm_pkg::CFG_MODULUS_P, p);
    write_reg(ecsm_pkg::CFG_CURVE_A, a);
    cfg_valid <= 1'b0;
    small_p = (sb.prime_p < 70000);
  endtask

  // send one word; bursts with random gaps between them
  task automatic send_word(logic [31:0] k, logic [30:0] x, logic [30:0] y);
    ecsm_pkg::in_t w;
    int            gap;
    w.scalar  = k;
    w.point_x = x;
    w.point_y = y;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 8));
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 20));
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  task automatic send_random();
    logic [31:0] k;
    logic [30:0] x, y;
    if (small_p && $urandom_range(0, 5) == 0) k = $urandom;
    else k = $urandom_range(0, 63);
    x = 31'($urandom);
    y = 31'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      x = 31'(longint'(x) % sb.prime_p);
      y = 31'(longint'(y) % sb.prime_p);
    end
    if ($urandom_range(0, 15) == 0) y = '0;
    if ($urandom_range(0, 31) == 0) begin
      x = '0;
      y = '0;
    end
    send_word(k, x, y);
  endtask

  initial begin
    sb         = new();
    burst_left = 0;
    small_p    = 1'b1;
    start      = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset field, p = 3
    send_word(32'd5, 31'd1, 31'd1);
    send_word(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFE);

    // directed on a small prime field
    set_field(32'd2, 32'd97);
    send_word(32'd0, 31'd3, 31'd6);
    send_word(32'd7, 31'd0, 31'd0);
    send_word(32'd7, 31'd97, 31'd194);
    send_word(32'd1, 31'd3, 31'd6);
    send_word(32'd2, 31'd3, 31'd6);
    send_word(32'd3, 31'd3, 31'd6);
    send_word(32'd2, 31'd5, 31'd0);
    send_word(32'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF, 31'd3, 31'd6);
    send_word(32'h8000_0000, 31'd3, 31'd6);
    send_word(32'd5, 31'd3, 31'd6);
    send_word(32'd50, 31'd3, 31'd6);

    // largest prime, masking of bit 31 and a at or above p
    set_field(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd3, 31'd12345, 31'd67890);
    send_word(32'hFFFF_FFFF, 31'h7FFF_FFFE, 31'h5555_5555);

    // modulus below 3
    set_field(32'd1, 32'd2);
    send_word(32'd9, 31'd1, 31'd1);
    set_field(32'd0, 32'd0);
    send_word(32'd9, 31'd1, 31'd1);

    // random phases over several fields
    set_field(32'd0, 32'd7);
    repeat (20) send_random();
    set_field($urandom_range(0, 250), 32'd251);
    repeat (25) send_random();
    set_field(32'd0, 32'd9);
    repeat (15) send_random();
    set_field($urandom_range(0, 65520), 32'd65521);
    repeat (25) send_random();
    set_field(32'h7FFF_FFFE, 32'h7FFF_FFFF);
    repeat (8) send_random();
    set_field($urandom, 32'd2147483629);
    repeat (6) send_random();
    set_field($urandom_range(0, 12), 32'd13);
    repeat (25) send_random();
    set_field(32'd0, 32'd1);
    repeat (5) send_random();

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
